// ----- hdl/pwlcm_pkg.sv -----
// Shared types, codes and widths of the piecewise-linear curve map.
`default_nettype none
package pwlcm_pkg;

  // Widths of the item fields.
  localparam int COORD_W  = 16;
  localparam int KIND_W   = 2;
  localparam int PIDX_W   = 4;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  // Widths of the stored slope and offset words.
  localparam int SLOPE_W  = 40;
  localparam int OFFSET_W = 40;

  // Default configuration of the top level.
  localparam int MAX_POINTS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PREP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVAL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

endpackage
`default_nettype wire

// ----- hdl/pwlcm_ifs.sv -----
// Channel interfaces of the piecewise-linear curve map.
`default_nettype none
interface pwlcm_sample_if;
  import pwlcm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic [PIDX_W-1:0]          point_index;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic signed [COORD_W-1:0]  sample_in;
  modport source (output valid, kind, point_index, point_x, point_y, sample_in, input ready);
  modport sink (input valid, kind, point_index, point_x, point_y, sample_in, output ready);
endinterface

interface pwlcm_result_if;
  import pwlcm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  mapped_value;
  logic [STATUS_W-1:0]        status;
  modport source (output valid, mapped_value, status, input ready);
  modport sink (input valid, mapped_value, status, output ready);
endinterface

interface pwlcm_cfg_if;
  import pwlcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  point_count;
  modport source (output valid, point_count, input ready);
  modport sink (input valid, point_count, output ready);
endinterface
`default_nettype wire

// ----- hdl/piecewise_linear_curve_map.sv -----
// Piecewise-linear curve map: breakpoint table, slope preparation and sample evaluation.
//
//   Channel   Dir  Carries
//   sample    in   kind, point_index, point_x, point_y, sample_in
//   result    out  mapped_value, status
//   cfg       in   point_count
//
// A load writes one breakpoint into the tables. An evaluate runs a segment search
// that reads breakpoints through the registered memory port, then a shift-add multiply.
// A prepare runs an order check over the points in use, then for each segment the
// bit-serial divider and the shared shift-add multiplier.
// Reset clears the sequencer, the result valid flag and point_count; tables are not cleared.
// The sample channel is ready only in the idle state; a result waits in its output
// register while the next item is taken, and the sequencer stalls at its end until it drains.
`default_nettype none
module piecewise_linear_curve_map #(
  parameter int MAX_POINTS = pwlcm_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = pwlcm_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  pwlcm_sample_if.sink          sample,
  pwlcm_result_if.source        result,
  pwlcm_cfg_if.sink             cfg
);
  import pwlcm_pkg::*;

  localparam int IW     = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int DIVW   = COORD_W + FRAC_BITS + 1;
  localparam int BCW    = $clog2(DIVW + 1);
  localparam int PROD_W = SLOPE_W + COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_FIN, S_MUL,
    P_CHK_W0, P_CHK_0, P_CHK_W, P_CHK,
    P_SEG_W0, P_SEG_0, P_SEG_W, P_SEG, P_DIV, P_KSET, P_OFF,
    E_W0, E_0, E_W1, E_1, E_W2, E_2, E_WK, E_K, E_RND, E_ADD
  } state_t;

  state_t state;

  // Breakpoint, slope and offset memories with registered read data.
  logic signed [COORD_W-1:0]  x_mem [MAX_POINTS];
  logic signed [COORD_W-1:0]  y_mem [MAX_POINTS];
  logic signed [SLOPE_W-1:0]  k_mem [MAX_POINTS];
  logic signed [OFFSET_W-1:0] d_mem [MAX_POINTS];
  logic signed [COORD_W-1:0]  x_rd, y_rd;
  logic signed [SLOPE_W-1:0]  k_rd;
  logic signed [OFFSET_W-1:0] d_rd;

  logic [CNT_W-1:0]           point_count;
  logic [IW-1:0]              addr;
  logic [IW-1:0]              seg;
  logic [CW-1:0]              idx;
  logic [CW-1:0]              cnt;
  logic                       bad;
  logic                       is_eval;
  logic signed [COORD_W-1:0]  xs;
  logic signed [COORD_W-1:0]  x0r, y0r, x1r, y1r;
  logic                       sgn;
  logic [COORD_W-1:0]         dvs;
  logic [DIVW-1:0]            num;
  logic [COORD_W-1:0]         rem;
  logic [BCW-1:0]             bcnt;
  logic signed [SLOPE_W-1:0]  kreg;
  logic [SLOPE_W-1:0]         mcand;
  logic [COORD_W-1:0]         mplier;
  logic [PROD_W-1:0]          acc;
  logic                       msgn;
  logic signed [OFFSET_W-1:0] dreg;
  logic signed [PROD_W:0]     treg;
  logic                       out_valid;
  logic signed [COORD_W-1:0]  out_value;
  logic [STATUS_W-1:0]        out_status;
  logic signed [COORD_W-1:0]  res_value;
  logic [STATUS_W-1:0]        res_status;

  logic                       in_fire;
  logic [CW-1:0]              n_act;
  logic                       ld_we;
  logic                       kd_we;
  logic signed [COORD_W:0]    dy, dx;
  logic [COORD_W-1:0]         dy_mag;
  logic [COORD_W:0]           trial;
  logic                       trial_ge;
  logic [PROD_W-1:0]          q_off;
  logic signed [OFFSET_W-1:0] d_wr;
  logic signed [PROD_W:0]     prod_s;
  logic signed [SUM_W-1:0]    sum;

  assign sample.ready       = (state == S_IDLE);
  assign in_fire            = sample.valid && sample.ready;
  assign cfg.ready          = 1'b1;
  assign result.valid       = out_valid;
  assign result.mapped_value = out_value;
  assign result.status      = out_status;

  // Points in use, limited to the table depth.
  assign n_act = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);

  assign ld_we = in_fire && (sample.kind == KIND_LOAD) &&
                 (32'(sample.point_index) < MAX_POINTS);
  assign kd_we = (state == P_OFF);

  // Segment deltas and the divider's compare-subtract step.
  assign dy       = (COORD_W+1)'(y_rd) - (COORD_W+1)'(y0r);
  assign dx       = (COORD_W+1)'(x_rd) - (COORD_W+1)'(x0r);
  assign dy_mag   = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
  assign trial    = {rem, num[DIVW-1]};
  assign trial_ge = (trial >= {1'b0, dvs});

  // Offset rounding: magnitude rounded half away from zero, then signed.
  assign q_off = (acc + HALF) >> FRAC_BITS;
  assign d_wr  = OFFSET_W'(y0r) - (msgn ? -OFFSET_W'(q_off) : OFFSET_W'(q_off));

  // Signed product and final sum for an evaluate.
  assign prod_s = msgn ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  assign sum    = SUM_W'(treg) + SUM_W'(dreg);

  // Breakpoint memories.
  always_ff @(posedge clk) begin
    if (ld_we) begin
      x_mem[IW'(sample.point_index)] <= sample.point_x;
      y_mem[IW'(sample.point_index)] <= sample.point_y;
    end
    x_rd <= x_mem[addr];
    y_rd <= y_mem[addr];
  end

  // Slope and offset memories.
  always_ff @(posedge clk) begin
    if (kd_we) begin
      k_mem[seg] <= kreg;
      d_mem[seg] <= d_wr;
    end
    k_rd <= k_mem[addr];
    d_rd <= d_mem[addr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      point_count <= cfg.point_count;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output register fills from the end state or empties on a transfer.
      if (state == S_FIN && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cnt        <= n_act;
            xs         <= sample.sample_in;
            addr       <= '0;
            res_value  <= '0;
            res_status <= STATUS_OK;
            state      <= S_FIN;
            if (sample.kind == KIND_PREP || sample.kind == KIND_EVAL) begin
              if (n_act < CW'(2)) begin
                res_status <= STATUS_FEW;
              end else if (sample.kind == KIND_PREP) begin
                state <= P_CHK_W0;
              end else begin
                state <= E_W0;
              end
            end
          end
        end

        // Order check over all points in use.
        P_CHK_W0: state <= P_CHK_0;
        P_CHK_0: begin
          x0r   <= x_rd;
          bad   <= 1'b0;
          idx   <= CW'(1);
          addr  <= IW'(1);
          state <= P_CHK_W;
        end
        P_CHK_W: state <= P_CHK;
        P_CHK: begin
          x0r <= x_rd;
          if (idx == cnt - CW'(1)) begin
            if (bad || (x_rd <= x0r)) begin
              res_status <= STATUS_ORDER;
              state      <= S_FIN;
            end else begin
              addr  <= '0;
              state <= P_SEG_W0;
            end
          end else begin
            bad   <= bad || (x_rd <= x0r);
            idx   <= idx + CW'(1);
            addr  <= IW'(idx + CW'(1));
            state <= P_CHK_W;
          end
        end

        // Slope and offset for each segment.
        P_SEG_W0: state <= P_SEG_0;
        P_SEG_0: begin
          x0r   <= x_rd;
          y0r   <= y_rd;
          seg   <= '0;
          addr  <= IW'(1);
          state <= P_SEG_W;
        end
        P_SEG_W: state <= P_SEG;
        P_SEG: begin
          x1r   <= x_rd;
          y1r   <= y_rd;
          sgn   <= dy[COORD_W];
          dvs   <= dx[COORD_W-1:0];
          num   <= (DIVW'(dy_mag) << FRAC_BITS) + DIVW'(dx[COORD_W-1:1]);
          rem   <= '0;
          bcnt  <= BCW'(DIVW);
          state <= P_DIV;
        end
        P_DIV: begin
          rem  <= trial_ge ? COORD_W'(trial - {1'b0, dvs}) : trial[COORD_W-1:0];
          num  <= {num[DIVW-2:0], trial_ge};
          bcnt <= bcnt - BCW'(1);
          if (bcnt == BCW'(1)) begin
            state <= P_KSET;
          end
        end
        P_KSET: begin
          kreg    <= sgn ? -SLOPE_W'(num) : SLOPE_W'(num);
          mcand   <= SLOPE_W'(num);
          mplier  <= x0r[COORD_W-1] ? COORD_W'(-x0r) : COORD_W'(x0r);
          msgn    <= sgn ^ x0r[COORD_W-1];
          acc     <= '0;
          bcnt    <= BCW'(COORD_W);
          is_eval <= 1'b0;
          state   <= S_MUL;
        end
        P_OFF: begin
          if (CW'(seg) + CW'(2) == cnt) begin
            state <= S_FIN;
          end else begin
            x0r   <= x1r;
            y0r   <= y1r;
            seg   <= seg + IW'(1);
            addr  <= IW'(CW'(seg) + CW'(2));
            state <= P_SEG_W;
          end
        end

        // Shared shift-add multiplier, one multiplier bit per cycle.
        S_MUL: begin
          acc    <= (acc << 1) + (mplier[COORD_W-1] ? PROD_W'(mcand) : '0);
          mplier <= mplier << 1;
          bcnt   <= bcnt - BCW'(1);
          if (bcnt == BCW'(1)) begin
            state <= is_eval ? E_RND : P_OFF;
          end
        end

        // Segment search for an evaluate.
        E_W0: state <= E_0;
        E_0: begin
          if (xs <= x_rd) begin
            addr  <= '0;
            state <= E_WK;
          end else begin
            addr  <= IW'(cnt - CW'(1));
            state <= E_W1;
          end
        end
        E_W1: state <= E_1;
        E_1: begin
          if (xs >= x_rd) begin
            addr  <= IW'(cnt - CW'(2));
            state <= E_WK;
          end else begin
            idx   <= CW'(1);
            addr  <= IW'(1);
            state <= E_W2;
          end
        end
        E_W2: state <= E_2;
        E_2: begin
          if ((x_rd > xs) || (idx == cnt - CW'(1))) begin
            addr  <= IW'(idx - CW'(1));
            state <= E_WK;
          end else begin
            idx   <= idx + CW'(1);
            addr  <= IW'(idx + CW'(1));
            state <= E_W2;
          end
        end
        E_WK: state <= E_K;
        E_K: begin
          dreg    <= d_rd;
          mcand   <= k_rd[SLOPE_W-1] ? SLOPE_W'(-k_rd) : SLOPE_W'(k_rd);
          mplier  <= xs[COORD_W-1] ? COORD_W'(-xs) : COORD_W'(xs);
          msgn    <= k_rd[SLOPE_W-1] ^ xs[COORD_W-1];
          acc     <= '0;
          bcnt    <= BCW'(COORD_W);
          is_eval <= 1'b1;
          state   <= S_MUL;
        end
        E_RND: begin
          treg  <= (prod_s + $signed({1'b0, HALF})) >>> FRAC_BITS;
          state <= E_ADD;
        end
        E_ADD: begin
          if (sum > SUM_W'(32767)) begin
            res_value <= 16'sh7fff;
          end else if (sum < -SUM_W'(32768)) begin
            res_value <= 16'sh8000;
          end else begin
            res_value <= COORD_W'(sum);
          end
          state <= S_FIN;
        end

        // Hand the result to the output register once it is free.
        S_FIN: begin
          if (!out_valid || result.ready) begin
            out_value  <= res_value;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pwlcm_checker.sv -----
// Port-level checks of the piecewise-linear curve map and their binding.
`default_nettype none
module pwlcm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] mapped_value,
  input wire logic [1:0]  status
);
  import pwlcm_pkg::*;

  // The block works on one item at a time: after a transfer in it is busy.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample ready right after a transfer");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mapped_value) && $stable(status))
    else $error("result changed before its transfer");

  // Status never carries the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != STATUS_BAD)
    else $error("unused status code");

  // A failing status comes with a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> mapped_value == 16'd0)
    else $error("nonzero value with failing status");

endmodule

bind piecewise_linear_curve_map pwlcm_checker u_pwlcm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .mapped_value (result.mapped_value),
  .status       (result.status)
);
`default_nettype wire

// ----- sim/pwlcm_curve_checker.sv -----
// Checker for the curve map: tracks transfers, predicts each result and compares it.
module pwlcm_curve_checker (
  input  logic clk,
  input  logic rst,
  pwlcm_sample_if smp,
  pwlcm_result_if res,
  pwlcm_cfg_if    cfg,
  output int      errors,
  output int      pending
);
  import pwlcm_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;
  localparam int FB   = FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [COORD_W-1:0] value;
    logic [STATUS_W-1:0]       status;
  } curve_result_t;

  // Shadow copy of the curve state.
  logic [CNT_W-1:0]          count_reg;
  logic signed [COORD_W-1:0] knot_x [NPTS];
  logic signed [COORD_W-1:0] knot_y [NPTS];
  longint                    seg_slope [NPTS];
  longint                    seg_offset [NPTS];
  curve_result_t             awaited [$];

  // Division rounded to nearest, ties away from zero; den is positive.
  function automatic longint nearest_quot(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Works out the result of one accepted item and updates the shadow state.
  function automatic curve_result_t map_item(logic [KIND_W-1:0] kind, logic [PIDX_W-1:0] idx,
                                             logic signed [COORD_W-1:0] px,
                                             logic signed [COORD_W-1:0] py,
                                             logic signed [COORD_W-1:0] xs);
    curve_result_t r;
    int     n;
    int     seg;
    longint dy;
    longint dx;
    longint k;
    longint acc;
    r.value = '0;
    r.status = STATUS_OK;
    n = (count_reg > NPTS) ? NPTS : count_reg;
    if (kind == KIND_LOAD) begin
      knot_x[idx] = px;
      knot_y[idx] = py;
    end else if (kind == KIND_PREP) begin
      if (n < 2) begin
        r.status = STATUS_FEW;
      end else begin
        for (int i = 0; i + 1 < n; i++)
          if (knot_x[i+1] <= knot_x[i]) r.status = STATUS_ORDER;
        if (r.status == STATUS_OK) begin
          for (int i = 0; i + 1 < n; i++) begin
            dy = longint'(knot_y[i+1]) - longint'(knot_y[i]);
            dx = longint'(knot_x[i+1]) - longint'(knot_x[i]);
            k = nearest_quot(dy * (longint'(1) << FB), dx);
            seg_slope[i] = k;
            seg_offset[i] = longint'(knot_y[i]) -
                            nearest_quot(k * longint'(knot_x[i]), longint'(1) << FB);
          end
        end
      end
    end else if (kind == KIND_EVAL) begin
      if (n < 2) begin
        r.status = STATUS_FEW;
      end else begin
        seg = 0;
        if (xs <= knot_x[0]) begin
          seg = 0;
        end else if (xs >= knot_x[n-1]) begin
          seg = n - 2;
        end else begin
          for (int i = n - 2; i >= 0; i--)
            if (knot_x[i+1] > xs) seg = i;
        end
        acc = ((longint'(xs) * seg_slope[seg] + (longint'(1) << (FB - 1))) >>> FB)
              + seg_offset[seg];
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        r.value = acc[COORD_W-1:0];
      end
    end
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    curve_result_t want;
    if (rst) begin
      count_reg <= '0;
      awaited.delete();
      errors <= errors;
    end else begin
      if (cfg.valid && cfg.ready) count_reg <= cfg.point_count;
      if (smp.valid && smp.ready)
        awaited.push_back(map_item(smp.kind, smp.point_index, smp.point_x,
                                   smp.point_y, smp.sample_in));
      if (res.valid && res.ready) begin
        if (awaited.size() == 0) begin
          report("result transfer with nothing awaited");
        end else begin
          want = awaited.pop_front();
          if (res.status !== want.status)
            report($sformatf("status %0d, predicted %0d", res.status, want.status));
          if (res.mapped_value !== want.value)
            report($sformatf("mapped_value %0d, predicted %0d",
                             res.mapped_value, want.value));
        end
      end
    end
    pending = awaited.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule

// ----- sim/tb_piecewise_linear_curve_map.sv -----
// Testbench top for the curve map: clock, reset, stimulus, stalls and verdict.
module tb_piecewise_linear_curve_map;
  import pwlcm_pkg::*;

  localparam int WATCH_LIMIT = 30000;
  localparam int SQUEEZE_LEN = 300;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  bit   calm;
  bit   squeeze_req;
  bit   squeeze_done;
  int   idle_cycles;
  int   items_sent;
  int   evals_sent;
  int   preps_sent;
  int   count_writes;

  pwlcm_sample_if smp ();
  pwlcm_result_if res ();
  pwlcm_cfg_if    cfg ();

  piecewise_linear_curve_map uut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg)
  );

  pwlcm_curve_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .smp     (smp),
    .res     (res),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  // Clock with a period of 4.
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("[piecewise_linear_curve_map] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls per result, plus one long hold-off.
  initial begin
    int w;
    res.ready = 0;
    squeeze_done = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        res.ready = 0;
        repeat (SQUEEZE_LEN) @(negedge clk);
        squeeze_done = 1;
      end
      w = calm ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        res.ready = 0;
        repeat (w) @(negedge clk);
      end
      res.ready = 1;
      do @(posedge clk); while (!res.valid);
      @(negedge clk);
    end
  end

  // One item on the sample channel, after a random gap.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [PIDX_W-1:0] idx,
                           logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                           logic [COORD_W-1:0] xs);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      smp.valid = 0;
      repeat (gap) @(negedge clk);
    end
    smp.valid = 1;
    smp.kind = kind;
    smp.point_index = idx;
    smp.point_x = px;
    smp.point_y = py;
    smp.sample_in = xs;
    do @(posedge clk); while (!smp.ready);
    @(negedge clk);
    items_sent++;
    if (kind == KIND_EVAL) evals_sent++;
    if (kind == KIND_PREP) preps_sent++;
  endtask

  // Waits until every result has come back, then writes point_count.
  task automatic set_count(logic [CNT_W-1:0] n);
    smp.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg.valid = 1;
    cfg.point_count = n;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 0;
    count_writes++;
  endtask

  // Loads n points with distinct rising x in slots 0 to n-1.
  task automatic load_rising(int n);
    int xs[$];
    int v;
    xs.delete();
    while (xs.size() < n) begin
      v = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 0) ? -32768 : 32767)
                                      : int'($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(0, 3) == 0 && xs.size() > 0) v = xs[$] + $urandom_range(1, 40);
      if (v > 32767) v = 32767;
      if (!(v inside {xs})) xs.push_back(v);
      xs.sort();
    end
    for (int i = 0; i < n; i++)
      send_item(KIND_LOAD, i[PIDX_W-1:0], xs[i][COORD_W-1:0], 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int n;
    int phase;
    logic [CNT_W-1:0] cnt;
    logic [COORD_W-1:0] xv;
    rst = 1;
    calm = 0;
    squeeze_req = 0;
    items_sent = 0;
    evals_sent = 0;
    preps_sent = 0;
    count_writes = 0;
    smp.valid = 0;
    smp.kind = KIND_LOAD;
    smp.point_index = '0;
    smp.point_x = '0;
    smp.point_y = '0;
    smp.sample_in = '0;
    cfg.valid = 0;
    cfg.point_count = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: full table spanning both coordinate extremes.
    set_count(16);
    for (int i = 0; i < 16; i++) begin
      xv = (i == 15) ? 16'h7fff : 16'(-32768 + i * 4369);
      send_item(KIND_LOAD, i[PIDX_W-1:0], xv, (i % 2 == 0) ? 16'h8000 : 16'h7fff, '0);
    end
    send_item(KIND_PREP, '0, '0, '0, '0);
    send_item(KIND_EVAL, '0, '0, '0, 16'h8000);
    send_item(KIND_EVAL, '0, '0, '0, 16'h7fff);
    send_item(KIND_EVAL, '0, '0, '0, 16'h0000);
    send_item(KIND_NONE, 4'hf, 16'hffff, 16'hffff, 16'hffff);
    // Out-of-order x: prepare fails and evaluation keeps the stale curve.
    send_item(KIND_LOAD, 4'd5, 16'h8000, 16'h1234, '0);
    send_item(KIND_PREP, '0, '0, '0, '0);
    send_item(KIND_EVAL, '0, '0, '0, 16'hc000);
    // Too few points for prepare and evaluate.
    set_count(0);
    send_item(KIND_PREP, '0, '0, '0, '0);
    send_item(KIND_EVAL, '0, '0, '0, 16'h0100);
    set_count(1);
    send_item(KIND_EVAL, '0, '0, '0, 16'h0100);
    // Count above the table size acts as a full table.
    set_count(31);
    send_item(KIND_LOAD, 4'd5, 16'(-32768 + 5 * 4369), 16'h0000, '0);
    send_item(KIND_PREP, '0, '0, '0, '0);
    send_item(KIND_EVAL, '0, '0, '0, 16'h1111);

    // Random phases: mostly well-formed curves, some noise.
    phase = 0;
    while (items_sent < 920) begin
      case ($urandom_range(0, 7))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = 2;
        3: cnt = 16;
        4: cnt = 5'($urandom_range(17, 31));
        default: cnt = 5'($urandom_range(2, 16));
      endcase
      set_count(cnt);
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 3) squeeze_req = 1;
      n = (cnt > 16) ? 16 : cnt;
      if ($urandom_range(0, 3) != 0) begin
        if (n > 0) load_rising(n);
        send_item(KIND_PREP, '0, '0, '0, '0);
        repeat ($urandom_range(4, 12))
          send_item(KIND_EVAL, '0, '0, '0, 16'($urandom));
      end else begin
        repeat ($urandom_range(6, 15))
          send_item(2'($urandom_range(0, 3)), 4'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
      end
      phase++;
    end

    // Drain and settle.
    smp.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Run covered %0d items (%0d evaluates, %0d prepares) over %0d count settings,",
             items_sent, evals_sent, preps_sent, count_writes);
    $display("including empty, single-point, full and oversized counts and a long output stall.");
    if (errors == 0 && pending == 0) begin
      $display("[piecewise_linear_curve_map] OK");
    end else begin
      $display("[piecewise_linear_curve_map] ERROR");
    end
    $finish;
  end
endmodule
